### hdl/lifl_pkg.sv
// Shared types, sizes and codes of the lazy-init free-list allocator.
package lifl_pkg;

  localparam int unsigned BLOCKS = 256;
  localparam int unsigned IDX_W  = $clog2(BLOCKS);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [CNT_W-1:0] BLOCKS_CNT = CNT_W'(BLOCKS);

  // Request kinds.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  // Word index of the only register (paddr bit 2).
  localparam logic REG_BLOCKS_IN_USE = 1'b0;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_index;
    logic [CNT_W-1:0] free_blocks;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic alloc_start;
    logic alloc_end;
    logic free_do;
  } cmd_t;

endpackage

### hdl/lazy_init_free_list_allocator_unit.sv
// Top level of the lazy-init free-list block allocator.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid_i/in_stall_o   req_t  {func, block_index}
//   out      output     out_valid_o/out_stall_i rsp_t  {status, granted_index, free_blocks}
//   cfg      input      APB psel/penable/pready  blocks_in_use at byte address 0
//
// An allocate passes through ST_ALLOC, a free does not: the head's link is read from the
// link RAM, whose read data is registered, before the new head is known.
// Results wait in an output register; a new item is taken while the last
// result is handed over. Reset clears the control and pool registers; the
// link RAM needs no clearing, since lazy initialization writes each link
// before it is read.
module lazy_init_free_list_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lifl_pkg::req_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lifl_pkg::rsp_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lifl_pkg::ADDR_W-1:0] paddr,
  input  logic [lifl_pkg::DATA_W-1:0] pwdata,
  output logic [lifl_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import lifl_pkg::*;

  cmd_t             cmd;
  logic             cfg_we;
  logic [CNT_W-1:0] blocks_in_use;

  // Byte-lane bits of paddr are not decoded.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_BLOCKS_IN_USE);
  assign prdata = (paddr[2] == REG_BLOCKS_IN_USE) ? DATA_W'(blocks_in_use) : '0;

  lifl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  lifl_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_i          (in_data_i),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[CNT_W-1:0]),
    .blocks_in_use_o(blocks_in_use),
    .rsp_o          (out_data_o)
  );

endmodule

### hdl/lifl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lifl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/lifl_dpath.sv
// Datapath: pool registers, link memory and the result register.
module lifl_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lifl_pkg::cmd_t             cmd_i,
  input  lifl_pkg::req_t             req_i,
  input  logic                       cfg_we_i,
  input  logic [lifl_pkg::CNT_W-1:0] cfg_wdata_i,
  output logic [lifl_pkg::CNT_W-1:0] blocks_in_use_o,
  output lifl_pkg::rsp_t             rsp_o
);
  import lifl_pkg::*;

  logic [CNT_W-1:0] blocks_q, blocks_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic             head_valid_q, head_valid_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] init_q, init_d;
  logic             hit_q, hit_d;
  logic [CNT_W-1:0] hit_val_q, hit_val_d;
  rsp_t             rsp_q, rsp_d;

  logic [CNT_W-1:0] n, n_cfg;
  logic             lazy_wr;
  logic             can_pop;
  logic             bad_free;
  logic [CNT_W-1:0] nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [CNT_W-1:0] mem_wdata;
  logic [CNT_W-1:0] mem_rdata;

  function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > BLOCKS_CNT) begin
      r = BLOCKS_CNT;
    end
    return r;
  endfunction

  assign n       = clamp_count(blocks_q);
  assign n_cfg   = clamp_count(cfg_wdata_i);
  assign lazy_wr = cmd_i.alloc_start && (init_q < n);
  assign can_pop = (free_q != '0) && head_valid_q && ({1'b0, head_q} < n);
  assign bad_free = ({1'b0, req_i.block_index} >= n) || (free_q >= n);
  // The lazy write lands in the same cycle as the head read; forward it.
  assign nxt     = hit_q ? hit_val_q : mem_rdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = init_q[IDX_W-1:0];
    mem_wdata = init_q + CNT_W'(1);
    if (lazy_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.free_do && !bad_free) begin
      mem_we    = 1'b1;
      mem_waddr = req_i.block_index;
      mem_wdata = head_valid_q ? {1'b0, head_q} : n;
    end
  end

  always_comb begin
    blocks_d     = blocks_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    free_d       = free_q;
    init_d       = init_q;
    hit_d        = hit_q;
    hit_val_d    = hit_val_q;
    rsp_d        = rsp_q;
    if (cfg_we_i) begin
      blocks_d     = cfg_wdata_i;
      free_d       = n_cfg;
      init_d       = '0;
      head_d       = '0;
      head_valid_d = 1'b1;
    end else if (cmd_i.alloc_start) begin
      hit_d     = lazy_wr && (init_q[IDX_W-1:0] == head_q);
      hit_val_d = init_q + CNT_W'(1);
      if (lazy_wr) begin
        init_d = init_q + CNT_W'(1);
      end
    end else if (cmd_i.alloc_end) begin
      rsp_d.status        = STATUS_EMPTY;
      rsp_d.granted_index = '0;
      rsp_d.free_blocks   = free_q;
      if (can_pop) begin
        rsp_d.status        = STATUS_OK;
        rsp_d.granted_index = head_q;
        rsp_d.free_blocks   = free_q - CNT_W'(1);
        free_d              = free_q - CNT_W'(1);
        if ((free_q > CNT_W'(1)) && (nxt < n)) begin
          head_d = nxt[IDX_W-1:0];
        end else begin
          head_d       = '0;
          head_valid_d = 1'b0;
        end
      end
    end else if (cmd_i.free_do) begin
      rsp_d.granted_index = '0;
      if (bad_free) begin
        rsp_d.status      = STATUS_BAD_FREE;
        rsp_d.free_blocks = free_q;
      end else begin
        rsp_d.status      = STATUS_OK;
        rsp_d.free_blocks = free_q + CNT_W'(1);
        free_d            = free_q + CNT_W'(1);
        head_d            = req_i.block_index;
        head_valid_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q     <= BLOCKS_CNT;
      head_q       <= '0;
      head_valid_q <= 1'b1;
      free_q       <= BLOCKS_CNT;
      init_q       <= '0;
      hit_q        <= 1'b0;
    end else begin
      blocks_q     <= blocks_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      free_q       <= free_d;
      init_q       <= init_d;
      hit_q        <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_val_q <= hit_val_d;
    rsp_q     <= rsp_d;
  end

  lifl_ram #(
    .Width(CNT_W),
    .Depth(BLOCKS)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (cmd_i.alloc_start),
    .raddr_i(head_q),
    .rdata_o(mem_rdata)
  );

  assign blocks_in_use_o = blocks_q;
  assign rsp_o           = rsp_q;

endmodule

### hdl/lifl_ctrl.sv
// Controller: request handshake, allocate sequencing and result valid.
module lifl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_func_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lifl_pkg::cmd_t cmd_o
);
  import lifl_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_ALLOC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic load;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.alloc_start = accept && (in_func_i == FUNC_ALLOC);
  assign cmd_o.free_do     = accept && (in_func_i == FUNC_FREE);
  assign cmd_o.alloc_end   = (state_q == ST_ALLOC);
  assign load              = cmd_o.free_do || cmd_o.alloc_end;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.alloc_start) begin
          state_d = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A pending result is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load)
    else $error("result register overwritten while stalled");

  // The result slot is free when an allocate finishes.
  a_alloc_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.alloc_start |=> (!out_valid_q && state_q == ST_ALLOC))
    else $error("allocate finishing into a busy result slot");

  // The finishing cycle always follows an accepted allocate.
  a_alloc_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.alloc_end |-> $past(cmd_o.alloc_start))
    else $error("allocate finish without a started allocate");

endmodule

### tb/lazy_init_free_list_allocator_unit_test.sv
// Self-checking testbench for the lazy-init free-list block allocator.
`timescale 1ns / 1ps

module lazy_init_free_list_allocator_unit_test;
  import lifl_pkg::*;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  req_t                in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  rsp_t                out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [DATA_W-1:0]   pwdata      = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  lazy_init_free_list_allocator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk_i = ~clk_i;

  // Pool state as the allocator should hold it.
  logic [CNT_W-1:0] pool_limit = BLOCKS_CNT;
  logic [CNT_W-1:0] link_ram   [BLOCKS];
  logic             link_known [BLOCKS];
  logic [IDX_W-1:0] head_blk;
  logic             head_live;
  logic [CNT_W-1:0] free_cnt;
  logic [CNT_W-1:0] init_cnt;

  req_t             req_pending [$];
  rsp_t             rsp_planned [$];
  rsp_t             rsp_due     [$];
  logic [IDX_W-1:0] held_blocks [$];
  int unsigned      errors = 0;

  function automatic int unsigned pool_blocks();
    if (pool_limit == 0) return 1;
    if (pool_limit > BLOCKS) return BLOCKS;
    return pool_limit;
  endfunction

  function automatic void restart_pool();
    free_cnt  = CNT_W'(pool_blocks());
    init_cnt  = '0;
    head_blk  = '0;
    head_live = 1'b1;
  endfunction

  // True when an allocate now would follow a link that was never stored.
  function automatic bit alloc_reads_unset();
    int unsigned n;
    n = pool_blocks();
    if (free_cnt <= 1 || !head_live || head_blk >= n) return 0;
    if (link_known[head_blk]) return 0;
    return !(init_cnt < n && init_cnt == head_blk);
  endfunction

  function automatic rsp_t serve_request(req_t r);
    int unsigned n;
    rsp_t rsp;
    logic [CNT_W-1:0] nxt;
    n = pool_blocks();
    rsp = '0;
    rsp.status = STATUS_OK;
    if (r.func == FUNC_ALLOC) begin
      // Thread one more never-used block before popping the head.
      if (init_cnt < n) begin
        link_ram[init_cnt[IDX_W-1:0]]   = init_cnt + 1'b1;
        link_known[init_cnt[IDX_W-1:0]] = 1'b1;
        init_cnt++;
      end
      if (free_cnt > 0 && head_live && head_blk < n) begin
        rsp.granted_index = head_blk;
        free_cnt--;
        nxt = link_ram[head_blk];
        if (free_cnt > 0 && nxt < n) begin
          head_blk = nxt[IDX_W-1:0];
        end else begin
          head_blk  = '0;
          head_live = 1'b0;
        end
      end else begin
        rsp.status = STATUS_EMPTY;
      end
    end else begin
      if (r.block_index >= n || free_cnt >= n) begin
        rsp.status = STATUS_BAD_FREE;
      end else begin
        link_ram[r.block_index]   = head_live ? CNT_W'(head_blk) : CNT_W'(n);
        link_known[r.block_index] = 1'b1;
        head_blk  = r.block_index;
        head_live = 1'b1;
        free_cnt++;
      end
    end
    rsp.free_blocks = free_cnt;
    return rsp;
  endfunction

  task automatic note_error(string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic queue_request(logic f, logic [IDX_W-1:0] idx);
    req_t r;
    rsp_t rsp;
    r.func = f;
    r.block_index = idx;
    rsp = serve_request(r);
    req_pending.push_back(r);
    rsp_planned.push_back(rsp);
    if (rsp.status == STATUS_OK) begin
      if (f == FUNC_ALLOC) begin
        held_blocks.push_back(rsp.granted_index);
      end else begin
        foreach (held_blocks[k]) begin
          if (held_blocks[k] == idx) begin
            held_blocks.delete(k);
            break;
          end
        end
      end
    end
  endtask

  task automatic check_limit_reg();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_BLOCKS_IN_USE, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== DATA_W'(pool_limit))
      note_error($sformatf("blocks_in_use reads %0h, expected %0h", prdata, pool_limit));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_pool_limit(logic [CNT_W-1:0] value);
    logic [DATA_W-1:0] word;
    word = $urandom();
    word[CNT_W-1:0] = value;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BLOCKS_IN_USE, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pool_limit = value;
    restart_pool();
    held_blocks.delete();
    check_limit_reg();
  endtask

  // Hold off new items until every planned result has come back.
  task automatic drain_pool();
    while (rsp_planned.size() != 0 || rsp_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned n, roll, bias_left, alloc_bias, k;
    logic f;
    logic [IDX_W-1:0] idx;
    bias_left  = 0;
    alloc_bias = 50;
    for (int unsigned i = 0; i < count; i++) begin
      n = pool_blocks();
      // Swing between filling and emptying the pool.
      if (bias_left == 0) begin
        alloc_bias = $urandom_range(0, 1) ? 80 : 25;
        bias_left  = $urandom_range(4, 8 + n / 2);
      end
      bias_left--;
      roll = $urandom_range(0, 199);
      f    = FUNC_ALLOC;
      idx  = IDX_W'($urandom_range(0, BLOCKS - 1));
      if (roll < 5) begin
        f = FUNC_FREE;
        if (n < BLOCKS && free_cnt < n) idx = IDX_W'($urandom_range(n, BLOCKS - 1));
      end else if (roll == 5) begin
        f   = FUNC_FREE;
        idx = IDX_W'($urandom_range(0, n - 1));
      end else if (held_blocks.size() != 0 && $urandom_range(0, 99) >= alloc_bias) begin
        f   = FUNC_FREE;
        k   = $urandom_range(0, held_blocks.size() - 1);
        idx = held_blocks[k];
        held_blocks.delete(k);
      end
      if (f == FUNC_ALLOC && alloc_reads_unset()) f = FUNC_FREE;
      queue_request(f, idx);
    end
  endtask

  // Sender: bursts of items separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  bit          sending;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      sending = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        rsp_due.push_back(rsp_planned.pop_front());
        sending = 1'b0;
      end
      if (!sending) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (req_pending.size() != 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          in_valid_i <= 1'b1;
          in_data_i  <= req_pending.pop_front();
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(0, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that switches at random between no stall, light and heavy stall.
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(10, 80);
      end
      stall_left--;
      case (stall_mode)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 1) != 0);
        end
        default: begin
          out_stall_i <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  // Result checker.
  rsp_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rsp_due.size() == 0) begin
        note_error($sformatf("result with nothing outstanding: %p", out_data_o));
      end else begin
        want = rsp_due.pop_front();
        if (out_data_o.status !== want.status)
          note_error($sformatf("status %0d, expected %0d", out_data_o.status, want.status));
        if (out_data_o.granted_index !== want.granted_index)
          note_error($sformatf("granted_index %0d, expected %0d",
                               out_data_o.granted_index, want.granted_index));
        if (out_data_o.free_blocks !== want.free_blocks)
          note_error($sformatf("free_blocks %0d, expected %0d",
                               out_data_o.free_blocks, want.free_blocks));
      end
    end
  end

  initial begin
    #6_000_000;
    $display("lazy_init_free_list_allocator_unit test failed");
    $finish;
  end

  initial begin
    logic [CNT_W-1:0] cfg_plan [8];
    cfg_plan = '{9'd511, 9'd1, 9'd2, 9'd256, 9'd6, 9'd300, 9'd40, 9'd0};
    cfg_plan[7] = CNT_W'($urandom_range(1, BLOCKS));
    foreach (link_known[k]) link_known[k] = 1'b0;
    restart_pool();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_limit_reg();
    run_random(200);
    drain_pool();

    // Three blocks: bad and surplus frees, a double free of the head that
    // lazy init later overwrites, an early end of the list and an allocate
    // with free blocks counted but no valid head.
    set_pool_limit(9'd3);
    queue_request(FUNC_FREE, 8'd0);
    queue_request(FUNC_FREE, 8'd255);
    queue_request(FUNC_ALLOC, 8'd255);
    queue_request(FUNC_FREE, 8'd1);
    queue_request(FUNC_ALLOC, 8'd0);
    queue_request(FUNC_ALLOC, 8'd170);
    queue_request(FUNC_ALLOC, 8'd85);
    queue_request(FUNC_FREE, 8'd2);
    queue_request(FUNC_ALLOC, 8'd0);
    queue_request(FUNC_FREE, 8'd0);
    queue_request(FUNC_FREE, 8'd1);
    queue_request(FUNC_FREE, 8'd1);
    queue_request(FUNC_ALLOC, 8'd0);
    queue_request(FUNC_ALLOC, 8'd0);
    queue_request(FUNC_ALLOC, 8'd0);
    run_random(120);
    drain_pool();

    // A zero count acts as one block: emptied list and allocate when empty.
    set_pool_limit(9'd0);
    queue_request(FUNC_ALLOC, 8'd255);
    queue_request(FUNC_ALLOC, 8'd0);
    queue_request(FUNC_FREE, 8'd0);
    queue_request(FUNC_FREE, 8'd0);
    queue_request(FUNC_FREE, 8'd1);
    queue_request(FUNC_ALLOC, 8'd0);
    queue_request(FUNC_FREE, 8'd0);
    run_random(60);
    drain_pool();

    foreach (cfg_plan[p]) begin
      set_pool_limit(cfg_plan[p]);
      run_random(cfg_plan[p] >= 200 ? 260 : 140);
      drain_pool();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("lazy_init_free_list_allocator_unit test passed");
    end else begin
      $display("lazy_init_free_list_allocator_unit test failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/lifl_pkg.sv
hdl/lifl_ram.sv
hdl/lifl_dpath.sv
hdl/lifl_ctrl.sv
hdl/lazy_init_free_list_allocator_unit.sv
tb/lazy_init_free_list_allocator_unit_test.sv
